FILE: rtl/rvx_pkg.sv
// Shared types and constants for the RV32I integer execute unit.
// Holds instruction encodings, the decoded micro-op format and default sizes.
// No dependencies; compile this file first.
package rvx_pkg;

  localparam int XLEN            = 32;
  localparam int REG_COUNT       = 32;
  localparam int REG_IDX_W       = 5;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Major opcodes.
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;

  // funct7 values.
  localparam logic [6:0] F7_ZERO = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values for OP and OP-IMM.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 values for branches.
  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5;

  // {funct7, funct3} for the two OP encodings with the alternate funct7.
  localparam logic [9:0] F10_SUB = 10'b0100000000;
  localparam logic [9:0] F10_SRA = 10'b0100000101;

  typedef enum logic [1:0] {
    KIND_ALU     = 2'd0,
    KIND_BRANCH  = 2'd1,
    KIND_ILLEGAL = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ALU_ADD  = 4'd0,
    ALU_SUB  = 4'd1,
    ALU_SLL  = 4'd2,
    ALU_SLT  = 4'd3,
    ALU_SLTU = 4'd4,
    ALU_XOR  = 4'd5,
    ALU_SRL  = 4'd6,
    ALU_SRA  = 4'd7,
    ALU_OR   = 4'd8,
    ALU_AND  = 4'd9
  } alu_op_t;

  typedef enum logic [1:0] {
    BR_EQ = 2'd0,
    BR_NE = 2'd1,
    BR_LT = 2'd2,
    BR_GE = 2'd3
  } br_op_t;

  // Decoded instruction as it travels from the decoder to the execute stage.
  typedef struct packed {
    kind_t                  kind;
    alu_op_t                alu_op;
    br_op_t                 br_op;
    logic                   use_imm;
    logic [REG_IDX_W-1:0]   rd;
    logic [REG_IDX_W-1:0]   rs1;
    logic [REG_IDX_W-1:0]   rs2;
    logic [XLEN-1:0]        imm;
  } uop_t;

endpackage

FILE: rtl/rvx_chan_if.sv
// Valid/ready channel interfaces for the instruction and result streams.
// Depends on nothing; compile after rvx_pkg.sv.
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] executed_pc;
  logic [31:0] next_pc;
  logic        write_enable;
  logic [4:0]  dest_index;
  logic [31:0] write_value;
  logic        branch_taken;
  logic        illegal;

  modport source (output valid, output executed_pc, output next_pc, output write_enable,
                  output dest_index, output write_value, output branch_taken,
                  output illegal, input ready);
  modport sink   (input valid, input executed_pc, input next_pc, input write_enable,
                  input dest_index, input write_value, input branch_taken,
                  input illegal, output ready);
endinterface

FILE: rtl/rvx_decode.sv
// Front end: takes instruction beats and classifies them into micro-ops.
// Depends on rvx_pkg and rvx_in_if.
module rvx_decode (
  rvx_in_if.sink            in_if,
  output logic              push_valid,
  input  logic              push_ready,
  output rvx_pkg::uop_t     push_uop
);

  logic [31:0] insn;
  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;

  assign insn       = in_if.instruction;
  assign opcode     = insn[6:0];
  assign f3         = insn[14:12];
  assign f7         = insn[31:25];
  assign push_valid = in_if.valid;
  assign in_if.ready = push_ready;

  always_comb begin
    push_uop         = '0;
    push_uop.kind    = rvx_pkg::KIND_ILLEGAL;
    push_uop.alu_op  = rvx_pkg::ALU_ADD;
    push_uop.br_op   = rvx_pkg::BR_EQ;
    push_uop.rd      = insn[11:7];
    push_uop.rs1     = insn[19:15];
    push_uop.rs2     = insn[24:20];
    push_uop.use_imm = 1'b0;
    push_uop.imm     = {{20{insn[31]}}, insn[31:20]};
    case (opcode)
      rvx_pkg::OPC_OP_IMM: begin
        push_uop.kind    = rvx_pkg::KIND_ALU;
        push_uop.use_imm = 1'b1;
        case (f3)
          rvx_pkg::F3_ADD:  push_uop.alu_op = rvx_pkg::ALU_ADD;
          rvx_pkg::F3_SLT:  push_uop.alu_op = rvx_pkg::ALU_SLT;
          rvx_pkg::F3_SLTU: push_uop.alu_op = rvx_pkg::ALU_SLTU;
          rvx_pkg::F3_XOR:  push_uop.alu_op = rvx_pkg::ALU_XOR;
          rvx_pkg::F3_OR:   push_uop.alu_op = rvx_pkg::ALU_OR;
          rvx_pkg::F3_AND:  push_uop.alu_op = rvx_pkg::ALU_AND;
          rvx_pkg::F3_SLL: begin
            push_uop.alu_op = rvx_pkg::ALU_SLL;
            if (f7 != rvx_pkg::F7_ZERO) push_uop.kind = rvx_pkg::KIND_ILLEGAL;
          end
          default: begin
            if (f7 == rvx_pkg::F7_ZERO) begin
              push_uop.alu_op = rvx_pkg::ALU_SRL;
            end else if (f7 == rvx_pkg::F7_ALT) begin
              push_uop.alu_op = rvx_pkg::ALU_SRA;
            end else begin
              push_uop.kind = rvx_pkg::KIND_ILLEGAL;
            end
          end
        endcase
      end
      rvx_pkg::OPC_OP: begin
        push_uop.kind = rvx_pkg::KIND_ALU;
        case ({f7, f3})
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_ADD}:  push_uop.alu_op = rvx_pkg::ALU_ADD;
          rvx_pkg::F10_SUB:                     push_uop.alu_op = rvx_pkg::ALU_SUB;
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_SLL}:  push_uop.alu_op = rvx_pkg::ALU_SLL;
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_SLT}:  push_uop.alu_op = rvx_pkg::ALU_SLT;
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_SLTU}: push_uop.alu_op = rvx_pkg::ALU_SLTU;
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_XOR}:  push_uop.alu_op = rvx_pkg::ALU_XOR;
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_SR}:   push_uop.alu_op = rvx_pkg::ALU_SRL;
          rvx_pkg::F10_SRA:                     push_uop.alu_op = rvx_pkg::ALU_SRA;
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_OR}:   push_uop.alu_op = rvx_pkg::ALU_OR;
          {rvx_pkg::F7_ZERO, rvx_pkg::F3_AND}:  push_uop.alu_op = rvx_pkg::ALU_AND;
          default:                              push_uop.kind   = rvx_pkg::KIND_ILLEGAL;
        endcase
      end
      rvx_pkg::OPC_BRANCH: begin
        push_uop.kind = rvx_pkg::KIND_BRANCH;
        push_uop.imm  = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
        case (f3)
          rvx_pkg::F3_BEQ: push_uop.br_op = rvx_pkg::BR_EQ;
          rvx_pkg::F3_BNE: push_uop.br_op = rvx_pkg::BR_NE;
          rvx_pkg::F3_BLT: push_uop.br_op = rvx_pkg::BR_LT;
          rvx_pkg::F3_BGE: push_uop.br_op = rvx_pkg::BR_GE;
          default:         push_uop.kind  = rvx_pkg::KIND_ILLEGAL;
        endcase
      end
      default: push_uop.kind = rvx_pkg::KIND_ILLEGAL;
    endcase
  end

endmodule

FILE: rtl/rvx_queue.sv
// Small FIFO of decoded micro-ops between the decoder and the execute stage.
// Depends on rvx_pkg.
module rvx_queue #(
  parameter int DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  rvx_pkg::uop_t push_uop,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rvx_pkg::uop_t pop_uop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rvx_pkg::uop_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_uop    = slot_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_uop;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy exceeds its depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not grow on a lone push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

FILE: rtl/rvx_exec.sv
// Back end: register file, operand bypass, ALU/branch unit, pc and result register.
// Depends on rvx_pkg and rvx_out_if.
module rvx_exec (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  rvx_pkg::uop_t pop_uop,
  rvx_out_if.source     out_if
);

  localparam int XLEN = rvx_pkg::XLEN;
  localparam int IW   = rvx_pkg::REG_IDX_W;

  // Register file: 32 x 32 memory plus one valid bit per entry.
  logic [XLEN-1:0]              rf_mem [rvx_pkg::REG_COUNT];
  logic [rvx_pkg::REG_COUNT-1:0] rf_vld_r;

  // Execute stage registers.
  logic            x_vld_r;
  rvx_pkg::uop_t   x_uop_r;
  logic [XLEN-1:0] rs1_raw_r, rs2_raw_r;
  logic            rs1_ok_r, rs2_ok_r;

  // Last register write, for reads that raced with it.
  logic            byp_en_r;
  logic [IW-1:0]   byp_idx_r;
  logic [XLEN-1:0] byp_val_r;

  logic [XLEN-1:0] pc_r;

  // Result register.
  logic            out_vld_r;
  logic [XLEN-1:0] out_pc_r, out_next_r, out_val_r;
  logic            out_wen_r, out_taken_r, out_ill_r;
  logic [IW-1:0]   out_rd_r;

  logic            x_fire, x_load;
  logic [XLEN-1:0] op_a, op_b, op_b_src, alu_res;
  logic [4:0]      sh;
  logic            lt_s, lt_u;
  logic            ex_wen, ex_taken, ex_ill;
  logic [XLEN-1:0] ex_val, ex_next;
  logic [IW-1:0]   ex_rd;

  assign x_fire    = x_vld_r && (!out_vld_r || out_if.ready);
  assign x_load    = pop_valid && (!x_vld_r || x_fire);
  assign pop_ready = !x_vld_r || x_fire;

  always_comb begin
    if (byp_en_r && byp_idx_r == x_uop_r.rs1) begin
      op_a = byp_val_r;
    end else begin
      op_a = rs1_ok_r ? rs1_raw_r : '0;
    end
    if (byp_en_r && byp_idx_r == x_uop_r.rs2) begin
      op_b = byp_val_r;
    end else begin
      op_b = rs2_ok_r ? rs2_raw_r : '0;
    end
  end

  assign op_b_src = x_uop_r.use_imm ? x_uop_r.imm : op_b;
  assign sh       = op_b_src[4:0];
  assign lt_s     = $signed(op_a) < $signed(op_b_src);
  assign lt_u     = op_a < op_b_src;

  always_comb begin
    case (x_uop_r.alu_op)
      rvx_pkg::ALU_ADD:  alu_res = op_a + op_b_src;
      rvx_pkg::ALU_SUB:  alu_res = op_a - op_b_src;
      rvx_pkg::ALU_SLL:  alu_res = op_a << sh;
      rvx_pkg::ALU_SLT:  alu_res = {{(XLEN-1){1'b0}}, lt_s};
      rvx_pkg::ALU_SLTU: alu_res = {{(XLEN-1){1'b0}}, lt_u};
      rvx_pkg::ALU_XOR:  alu_res = op_a ^ op_b_src;
      rvx_pkg::ALU_SRL:  alu_res = op_a >> sh;
      rvx_pkg::ALU_SRA:  alu_res = XLEN'($signed(op_a) >>> sh);
      rvx_pkg::ALU_OR:   alu_res = op_a | op_b_src;
      rvx_pkg::ALU_AND:  alu_res = op_a & op_b_src;
      default:           alu_res = '0;
    endcase
  end

  always_comb begin
    ex_wen   = 1'b0;
    ex_taken = 1'b0;
    ex_ill   = 1'b0;
    ex_val   = '0;
    ex_rd    = '0;
    ex_next  = pc_r + XLEN'(4);
    case (x_uop_r.kind)
      rvx_pkg::KIND_ALU: begin
        ex_wen = (x_uop_r.rd != '0);
        ex_val = ex_wen ? alu_res : '0;
        ex_rd  = ex_wen ? x_uop_r.rd : '0;
      end
      rvx_pkg::KIND_BRANCH: begin
        case (x_uop_r.br_op)
          rvx_pkg::BR_EQ: ex_taken = (op_a == op_b);
          rvx_pkg::BR_NE: ex_taken = (op_a != op_b);
          rvx_pkg::BR_LT: ex_taken = lt_s;
          rvx_pkg::BR_GE: ex_taken = !lt_s;
          default:        ex_taken = 1'b0;
        endcase
        if (ex_taken) ex_next = pc_r + x_uop_r.imm;
      end
      default: begin
        ex_ill  = 1'b1;
        ex_next = pc_r;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      byp_en_r  <= 1'b0;
      rf_vld_r  <= '0;
      pc_r      <= '0;
      rs1_ok_r  <= 1'b0;
      rs2_ok_r  <= 1'b0;
    end else begin
      if (x_load) begin
        x_vld_r  <= 1'b1;
        rs1_ok_r <= rf_vld_r[pop_uop.rs1];
        rs2_ok_r <= rf_vld_r[pop_uop.rs2];
      end else if (x_fire) begin
        x_vld_r <= 1'b0;
      end
      if (x_fire) begin
        out_vld_r <= 1'b1;
        pc_r      <= ex_next;
        if (ex_wen) begin
          rf_vld_r[ex_rd] <= 1'b1;
          byp_en_r        <= 1'b1;
        end
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload and register file memory.
  always_ff @(posedge clk) begin
    if (x_load) begin
      x_uop_r   <= pop_uop;
      rs1_raw_r <= rf_mem[pop_uop.rs1];
      rs2_raw_r <= rf_mem[pop_uop.rs2];
    end
    if (x_fire) begin
      out_pc_r    <= pc_r;
      out_next_r  <= ex_next;
      out_wen_r   <= ex_wen;
      out_rd_r    <= ex_rd;
      out_val_r   <= ex_val;
      out_taken_r <= ex_taken;
      out_ill_r   <= ex_ill;
      if (ex_wen) begin
        rf_mem[ex_rd] <= ex_val;
        byp_idx_r     <= ex_rd;
        byp_val_r     <= ex_val;
      end
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.executed_pc  = out_pc_r;
  assign out_if.next_pc      = out_next_r;
  assign out_if.write_enable = out_wen_r;
  assign out_if.dest_index   = out_rd_r;
  assign out_if.write_value  = out_val_r;
  assign out_if.branch_taken = out_taken_r;
  assign out_if.illegal      = out_ill_r;

`ifndef SYNTH
  a_pc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (pc_r == out_next_r))
    else $error("pc does not match the next pc of the pending result");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ill_r) |-> (!out_wen_r && !out_taken_r && out_next_r == out_pc_r))
    else $error("illegal instruction changed state");

  a_x0_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0] && (!byp_en_r || byp_idx_r != '0))
    else $error("register x0 was written");
`endif

endmodule

FILE: rtl/rv32i_integer_execute_unit.sv
// Top level of the RV32I integer execute unit.
// Depends on rvx_pkg, rvx_chan_if, rvx_decode, rvx_queue and rvx_exec.
//
// This unit executes a stream of RV32I instruction words (OP-IMM, OP and the
// branches beq, bne, blt, bge) against its own program counter and a 32 x 32
// register file, and delivers exactly one result beat per instruction beat,
// in order. Each result carries the instruction's pc, the next pc, any
// register write and the branch and illegal flags; an unsupported encoding
// leaves the pc and all registers unchanged. After reset the pc is zero and
// every register reads zero; the register file is cleared through one valid
// bit per entry, so no clearing pass is needed and the unit is ready at once.
// The front end decodes each instruction beat as it is taken and pushes it
// into a short queue; the back end reads the register file into the execute
// stage register, resolves a read that races with the previous write through
// a one-entry bypass, and computes the result into an output register. The
// sustained rate is one instruction per clock while the output is ready,
// set by the single execute stage with its register-file read and writeback.
// Each instruction passes through a queue entry, the execute stage register
// and the output register. While a finished result waits, the unit still
// holds one instruction in the execute stage and one per queue entry (two by
// default), and takes instruction beats until those are full.
module rv32i_integer_execute_unit #(
  parameter int QUEUE_DEPTH = rvx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rvx_in_if.sink     in_if,
  rvx_out_if.source  out_if
);

  logic          push_valid, push_ready;
  rvx_pkg::uop_t push_uop;
  logic          pop_valid, pop_ready;
  rvx_pkg::uop_t pop_uop;

  // Front end: classify each instruction beat.
  rvx_decode u_decode (
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop)
  );

  // Decouples decode from execute stalls.
  rvx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_uop   (push_uop),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_uop    (pop_uop)
  );

  // Back end: register file, execution and result register.
  rvx_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_uop   (pop_uop),
    .out_if    (out_if)
  );

endmodule
